// ===== rtl/cmsw_pkg.sv =====
`timescale 1ns / 1ps

package cmsw_pkg;

  // Field and register widths
  localparam int PIX_W      = 16;
  localparam int IDX_W      = 24;
  localparam int DIM_W      = 13;
  localparam int OFF_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Default largest plane dimension
  localparam int DEFAULT_MAX_DIM = 4096;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_WIDTH   = 3'd0,
    REG_IN_HEIGHT  = 3'd1,
    REG_OUT_WIDTH  = 3'd2,
    REG_OUT_HEIGHT = 3'd3,
    REG_ROW_OFFSET = 3'd4,
    REG_COL_OFFSET = 3'd5,
    REG_MIRROR     = 3'd6,
    REG_NO_ADJUST  = 3'd7
  } cfg_reg_e;

  // Configuration as seen by the datapath; sizes are already clamped
  typedef struct packed {
    logic [DIM_W-1:0] in_w;
    logic [DIM_W-1:0] in_h;
    logic [DIM_W-1:0] out_w;
    logic [DIM_W-1:0] out_h;
    logic [OFF_W-1:0] row_off;
    logic [OFF_W-1:0] col_off;
    logic             mirror;
    logic             no_adjust;
  } cfg_t;

  // One window pixel between the input stage and the output stage
  typedef struct packed {
    logic signed [PIX_W-1:0] pix;
    logic [IDX_W-1:0]        base;
    logic [DIM_W-1:0]        wcol;
  } beat_t;

endpackage

// ===== rtl/crop_mirror_scale_writer_core.sv =====
`timescale 1ns / 1ps
// An accepted window pixel enters the input register and moves on to the result
// register once that is free; the input register and the result register are the two stages.
// Throughput: one pixel per cycle; the input register and the result register
// each take a new beat while the next one drains, so only a stalled output stops it.
// Pixels outside the crop window are dropped and produce no output beat.
// Reset clears the row/column counters and valid flags and sets the config registers to their defaults.

module crop_mirror_scale_writer_core #(
  parameter int MAX_DIM = cmsw_pkg::DEFAULT_MAX_DIM
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cmsw_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cmsw_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [cmsw_pkg::PIX_W-1:0]  pixel_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [cmsw_pkg::IDX_W-1:0]         dest_index_o,
  output logic signed [cmsw_pkg::PIX_W-1:0]  pixel_out_o
);

  cmsw_pkg::cfg_t  cfg;
  cmsw_pkg::beat_t beat;
  logic            beat_valid;
  logic            beat_ready;

  cmsw_cfg_regs #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cmsw_addr_gen #(
    .MAX_DIM (MAX_DIM)
  ) u_addr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_in_i   (pixel_in_i),
    .beat_valid_o (beat_valid),
    .beat_ready_i (beat_ready),
    .beat_o       (beat)
  );

  cmsw_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .no_adjust_i  (cfg.no_adjust),
    .beat_valid_i (beat_valid),
    .beat_ready_o (beat_ready),
    .beat_i       (beat),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .dest_index_o (dest_index_o),
    .pixel_out_o  (pixel_out_o)
  );

  // Input only backs up when the output register is full and stalled
  in_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output can drain");

endmodule

// ===== rtl/cmsw_cfg_regs.sv =====
`timescale 1ns / 1ps

module cmsw_cfg_regs #(
  parameter int MAX_DIM = cmsw_pkg::DEFAULT_MAX_DIM
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cmsw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cmsw_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output cmsw_pkg::cfg_t                  cfg_o
);

  cmsw_pkg::cfg_t                cfg_q;
  logic [cmsw_pkg::DIM_W-1:0]    dim_clamped;
  cmsw_pkg::cfg_reg_e            reg_sel;

  assign reg_sel = cmsw_pkg::cfg_reg_e'(cfg_idx_i);

  // Sizes are clamped to 1..MAX_DIM on the way in
  always_comb begin
    dim_clamped = cfg_wdata_i[cmsw_pkg::DIM_W-1:0];
    if (dim_clamped == '0) begin
      dim_clamped = cmsw_pkg::DIM_W'(1);
    end else if (int'(dim_clamped) > MAX_DIM) begin
      dim_clamped = cmsw_pkg::DIM_W'(MAX_DIM);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_w      <= cmsw_pkg::DIM_W'(1);
      cfg_q.in_h      <= cmsw_pkg::DIM_W'(1);
      cfg_q.out_w     <= cmsw_pkg::DIM_W'(1);
      cfg_q.out_h     <= cmsw_pkg::DIM_W'(1);
      cfg_q.row_off   <= '0;
      cfg_q.col_off   <= '0;
      cfg_q.mirror    <= 1'b0;
      cfg_q.no_adjust <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_sel)
        cmsw_pkg::REG_IN_WIDTH:   cfg_q.in_w      <= dim_clamped;
        cmsw_pkg::REG_IN_HEIGHT:  cfg_q.in_h      <= dim_clamped;
        cmsw_pkg::REG_OUT_WIDTH:  cfg_q.out_w     <= dim_clamped;
        cmsw_pkg::REG_OUT_HEIGHT: cfg_q.out_h     <= dim_clamped;
        cmsw_pkg::REG_ROW_OFFSET: cfg_q.row_off   <= cfg_wdata_i[cmsw_pkg::OFF_W-1:0];
        cmsw_pkg::REG_COL_OFFSET: cfg_q.col_off   <= cfg_wdata_i[cmsw_pkg::OFF_W-1:0];
        cmsw_pkg::REG_MIRROR:     cfg_q.mirror    <= cfg_wdata_i[0];
        cmsw_pkg::REG_NO_ADJUST:  cfg_q.no_adjust <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/cmsw_addr_gen.sv =====
`timescale 1ns / 1ps

module cmsw_addr_gen #(
  parameter int MAX_DIM = cmsw_pkg::DEFAULT_MAX_DIM
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cmsw_pkg::cfg_t                    cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [cmsw_pkg::PIX_W-1:0] pixel_in_i,
  output logic                              beat_valid_o,
  input  logic                              beat_ready_i,
  output cmsw_pkg::beat_t                   beat_o
);

  localparam int CW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  // signed compare width, wide enough for count, size and offset terms
  localparam int LW = ((CW > cmsw_pkg::DIM_W) ? CW : cmsw_pkg::DIM_W) + 2;

  logic [CW-1:0]                col_q, col_d;
  logic [CW-1:0]                row_q, row_d;
  logic [cmsw_pkg::IDX_W-1:0]   base_q, base_d;
  logic                         a_valid_q;
  cmsw_pkg::beat_t              a_beat_q;

  logic signed [LW-1:0] col_s, row_s, w_s, h_s, ow_s, oh_s, roff_s, coff_s;
  logic signed [LW-1:0] wrow, wcol;
  logic                 row_in, hit, col_end, row_end;
  logic                 a_ready, accept;

  // Widen everything to one signed width
  assign col_s  = signed'(LW'(col_q));
  assign row_s  = signed'(LW'(row_q));
  assign w_s    = signed'(LW'(cfg_i.in_w));
  assign h_s    = signed'(LW'(cfg_i.in_h));
  assign ow_s   = signed'(LW'(cfg_i.out_w));
  assign oh_s   = signed'(LW'(cfg_i.out_h));
  assign roff_s = signed'(LW'(cfg_i.row_off));
  assign coff_s = signed'(LW'(cfg_i.col_off));

  // Window position of the current pixel
  assign wrow   = row_s - roff_s;
  assign wcol   = cfg_i.mirror ? (w_s - coff_s - signed'(LW'(1)) - col_s)
                               : (col_s - coff_s);
  assign row_in = (wrow >= 0) && (wrow < oh_s);
  assign hit    = row_in && (wcol >= 0) && (wcol < ow_s);

  assign col_end = col_s >= (w_s - signed'(LW'(1)));
  assign row_end = row_s >= (h_s - signed'(LW'(1)));

  // Handshake: the stage takes a beat when empty or when it drains
  assign a_ready    = !a_valid_q || beat_ready_i;
  assign in_stall_o = !a_ready;
  assign accept     = in_valid_i && a_ready;

  // Raster counters, wrapping at row and plane end
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    base_d = base_q;
    if (col_end) begin
      col_d = '0;
      if (row_in) begin
        base_d = base_q + cmsw_pkg::IDX_W'(cfg_i.out_w);
      end
      if (row_end) begin
        row_d  = '0;
        base_d = '0;
      end else begin
        row_d = row_q + CW'(1);
      end
    end else begin
      col_d = col_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      base_q    <= '0;
      a_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q  <= col_d;
        row_q  <= row_d;
        base_q <= base_d;
      end
      if (a_ready) begin
        a_valid_q <= accept && hit;
      end
    end
  end

  // Input register: pixel plus its destination terms
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_beat_q.pix  <= pixel_in_i;
      a_beat_q.base <= base_q;
      a_beat_q.wcol <= wcol[cmsw_pkg::DIM_W-1:0];
    end
  end

  assign beat_valid_o = a_valid_q;
  assign beat_o       = a_beat_q;

  // A held beat keeps its contents until the output stage takes it
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !beat_ready_i) |=> (a_valid_q && $stable(a_beat_q)))
    else $error("input stage dropped or changed a held beat");

  // Column counter wraps to zero at the end of each row
  col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && col_end) |=> (col_q == '0))
    else $error("column counter did not wrap");

endmodule

// ===== rtl/cmsw_out_stage.sv =====
`timescale 1ns / 1ps

module cmsw_out_stage (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               no_adjust_i,
  input  logic                               beat_valid_i,
  output logic                               beat_ready_o,
  input  cmsw_pkg::beat_t                    beat_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [cmsw_pkg::IDX_W-1:0]         dest_index_o,
  output logic signed [cmsw_pkg::PIX_W-1:0]  pixel_out_o
);

  logic                              b_valid_q;
  logic [cmsw_pkg::IDX_W-1:0]        idx_q, idx_d;
  logic signed [cmsw_pkg::PIX_W-1:0] pix_q, pix_d;
  logic signed [cmsw_pkg::PIX_W+1:0] twice, shifted;
  logic                              b_ready;

  assign b_ready = !b_valid_q || !out_stall_i;

  // Destination index: row base plus window column, modulo 2^24
  assign idx_d = beat_i.base + cmsw_pkg::IDX_W'(beat_i.wcol);

  // 2x - 1 in Q1.15, saturated at the bottom; no_adjust passes the pixel through
  assign twice   = {beat_i.pix[cmsw_pkg::PIX_W-1], beat_i.pix, 1'b0};
  assign shifted = twice - (cmsw_pkg::PIX_W+2)'(32768);

  always_comb begin
    if (no_adjust_i) begin
      pix_d = beat_i.pix;
    end else if (shifted < -(cmsw_pkg::PIX_W+2)'(32768)) begin
      pix_d = {1'b1, {(cmsw_pkg::PIX_W-1){1'b0}}};
    end else begin
      pix_d = shifted[cmsw_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= beat_valid_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (b_ready && beat_valid_i) begin
      idx_q <= idx_d;
      pix_q <= pix_d;
    end
  end

  assign beat_ready_o = b_ready;
  assign out_valid_o  = b_valid_q;
  assign dest_index_o = idx_q;
  assign pixel_out_o  = pix_q;

  // The adjusted value 2x - 32768 is always even
  even_adj: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !no_adjust_i) |-> (pixel_out_o[0] == 1'b0))
    else $error("adjusted pixel has odd value");

endmodule
